// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== src/dtts_pkg.sv =====
// shared constants, types and the unit lookup for the duration text parser
// no dependencies
package dtts_pkg;

    localparam int CHAR_W      = 8;
    localparam int TOTAL_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int SCALE_W     = 20;
    localparam int APB_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_IDX_W   = CFG_ADDR_W - 2;

    localparam int QUEUE_DEPTH_DEF = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FALLBACK_UNIT = CFG_IDX_W'(0);

    // characters
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] UNIT_SEC   = 8'h73;
    localparam logic [CHAR_W-1:0] UNIT_MIN   = 8'h6D;
    localparam logic [CHAR_W-1:0] UNIT_HOUR  = 8'h68;
    localparam logic [CHAR_W-1:0] UNIT_DAY   = 8'h64;
    localparam logic [CHAR_W-1:0] UNIT_WEEK  = 8'h77;

    localparam logic [CHAR_W-1:0] FALLBACK_UNIT_RESET = UNIT_SEC;

    // seconds per unit
    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = SECS_PER_MIN * 60;
    localparam int SECS_PER_DAY  = SECS_PER_HOUR * 24;
    localparam int SECS_PER_WEEK = SECS_PER_DAY * 7;

    localparam logic [SCALE_W-1:0] SCALE_SEC  = SCALE_W'(1);
    localparam logic [SCALE_W-1:0] SCALE_MIN  = SCALE_W'(SECS_PER_MIN);
    localparam logic [SCALE_W-1:0] SCALE_HOUR = SCALE_W'(SECS_PER_HOUR);
    localparam logic [SCALE_W-1:0] SCALE_DAY  = SCALE_W'(SECS_PER_DAY);
    localparam logic [SCALE_W-1:0] SCALE_WEEK = SCALE_W'(SECS_PER_WEEK);

    // operations passed from front to back
    localparam logic [1:0] OP_DIGIT = 2'd0;
    localparam logic [1:0] OP_UNIT  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic               restart;     // digit opens a new number
        logic [DIGIT_W-1:0] digit;
        logic               use_number;  // unit applies to the pending number
        logic               known;       // unit is one of s m h d w
        logic [SCALE_W-1:0] scale;
    } dtts_entry_t;

    typedef struct packed {
        logic               known;
        logic [SCALE_W-1:0] scale;
    } dtts_unit_t;

    typedef struct packed {
        logic end_fire;
    } dtts_back_stat_t;

    function automatic dtts_unit_t unit_lookup(input logic [CHAR_W-1:0] c);
        dtts_unit_t r;
        r.known = 1'b1;
        case (c)
            UNIT_SEC:  r.scale = SCALE_SEC;
            UNIT_MIN:  r.scale = SCALE_MIN;
            UNIT_HOUR: r.scale = SCALE_HOUR;
            UNIT_DAY:  r.scale = SCALE_DAY;
            UNIT_WEEK: r.scale = SCALE_WEEK;
            default:
            begin
                r.known = 1'b0;
                r.scale = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== src/dtts_if.sv =====
// request channels of the duration text parser: characters in, totals out
// depends on dtts_pkg
interface dtts_char_if;
    logic                         valid;
    logic                         ready;
    logic [dtts_pkg::CHAR_W-1:0]  char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface dtts_result_if;
    logic                         valid;
    logic                         ready;
    logic [dtts_pkg::TOTAL_W-1:0] total_seconds;
    logic                         unknown_unit_seen;

    modport source (output valid, output total_seconds, output unknown_unit_seen,
                    input ready);
    modport sink   (input valid, input total_seconds, input unknown_unit_seen,
                    output ready);
endinterface

// ===== src/dtts_front.sv =====
// front end: accepts characters, tracks the term phase, emits operations
// depends on dtts_pkg and dtts_if
module dtts_front (
    input  logic                        clk,
    input  logic                        rst_n,
    dtts_char_if.sink                   text,
    input  logic [dtts_pkg::CHAR_W-1:0] fallback_unit,
    input  logic                        q_full,
    output logic                        push,
    output dtts_pkg::dtts_entry_t       entry
);
    import dtts_pkg::*;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_DELIM  = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic              accept;
    logic              in_digits;
    logic              is_digit;
    logic              is_delim;
    dtts_unit_t        char_unit;
    dtts_unit_t        dflt_unit;
    logic [CHAR_W-1:0] c;

    assign c          = text.char_code;
    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;
    assign in_digits  = (phase_reg == PH_DIGITS);
    assign is_digit   = c inside {[CHAR_ZERO:CHAR_NINE]};
    assign is_delim   = c inside {CHAR_SPACE, CHAR_COMMA, CHAR_DOT, CHAR_SEMI,
                                  CHAR_COLON, CHAR_SLASH};
    assign char_unit  = unit_lookup(c);
    assign dflt_unit  = unit_lookup(fallback_unit);

    always_comb
    begin
        phase_next       = phase_reg;
        push             = 1'b0;
        entry.op         = OP_UNIT;
        entry.restart    = !in_digits;
        entry.digit      = c[DIGIT_W-1:0];
        entry.use_number = in_digits;
        entry.known      = char_unit.known;
        entry.scale      = char_unit.scale;
        if (accept)
        begin
            if (c == CHAR_NUL)
            begin
                // trailing digits take the default unit, otherwise add nothing
                push        = 1'b1;
                entry.op    = OP_END;
                entry.known = in_digits ? dflt_unit.known : 1'b1;
                entry.scale = in_digits ? dflt_unit.scale : '0;
                phase_next  = PH_START;
            end
            else if (is_digit)
            begin
                push        = 1'b1;
                entry.op    = OP_DIGIT;
                entry.known = 1'b1;
                entry.scale = '0;
                phase_next  = PH_DIGITS;
            end
            else if (is_delim && !in_digits && phase_reg != PH_DELIM)
            begin
                // one delimiter at the start of a term is dropped here
                phase_next = PH_DELIM;
            end
            else
            begin
                push       = 1'b1;
                phase_next = PH_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== src/dtts_fifo.sv =====
// short operation queue between front and back
// depends on dtts_pkg
module dtts_fifo #(
    parameter int DEPTH = dtts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  dtts_pkg::dtts_entry_t         wr_entry,
    input  logic                          pop,
    output dtts_pkg::dtts_entry_t         rd_entry,
    output logic                          full,
    output logic                          empty,
    output logic [$clog2(DEPTH+1)-1:0]    level
);
    import dtts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    dtts_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (level_reg == LVL_W'(DEPTH));
    assign empty    = (level_reg == '0);
    assign level    = level_reg;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== src/dtts_back.sv =====
// back end: number build, unit multiply, accumulate and result register
// depends on dtts_pkg and dtts_if
module dtts_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  dtts_pkg::dtts_entry_t     q_entry,
    output logic                      q_pop,
    dtts_result_if.source             result,
    output dtts_pkg::dtts_back_stat_t stat
);
    import dtts_pkg::*;

    logic [TOTAL_W-1:0]         pending_reg;
    logic [TOTAL_W-1:0]         pending_next;
    logic [TOTAL_W-1:0]         total_reg;
    logic [TOTAL_W-1:0]         total_next;
    logic                       err_reg;
    logic                       err_next;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s1_end_reg;
    logic                       s1_end_next;
    logic                       s1_err_reg;
    logic                       s1_err_next;
    logic [TOTAL_W-1:0]         s1_product_reg;
    logic [TOTAL_W-1:0]         s1_product_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [TOTAL_W-1:0]         out_total_reg;
    logic [TOTAL_W-1:0]         out_total_next;
    logic                       out_err_reg;
    logic                       out_err_next;

    logic                       s1_stall;
    logic                       s1_fire;
    logic                       is_digit_op;
    logic [TOTAL_W-1:0]         number;
    logic [TOTAL_W+SCALE_W-1:0] prod_wide;
    logic [TOTAL_W-1:0]         base;
    logic [TOTAL_W-1:0]         sum;
    logic                       err_sum;

    assign s1_stall    = s1_valid_reg && s1_end_reg && out_valid_reg && !result.ready;
    assign s1_fire     = s1_valid_reg && !s1_stall;
    assign q_pop       = !q_empty && (!s1_valid_reg || s1_fire);
    assign is_digit_op = (q_entry.op == OP_DIGIT);
    assign number      = q_entry.use_number ? pending_reg : '0;
    assign prod_wide   = number * q_entry.scale;
    assign base        = q_entry.restart ? '0 : pending_reg;
    assign sum         = total_reg + s1_product_reg;
    assign err_sum     = err_reg | s1_err_reg;

    // stage one: pending number and unit product
    always_comb
    begin
        pending_next    = pending_reg;
        s1_valid_next   = s1_fire ? 1'b0 : s1_valid_reg;
        s1_end_next     = s1_end_reg;
        s1_err_next     = s1_err_reg;
        s1_product_next = s1_product_reg;
        if (q_pop)
        begin
            s1_valid_next   = 1'b1;
            s1_end_next     = (q_entry.op == OP_END);
            s1_err_next     = !is_digit_op && !q_entry.known;
            s1_product_next = (!is_digit_op && q_entry.known) ?
                              prod_wide[TOTAL_W-1:0] : '0;
            case (q_entry.op)
                OP_DIGIT: pending_next = (base << 3) + (base << 1)
                                         + TOTAL_W'(q_entry.digit);
                OP_UNIT:  pending_next = '0;
                OP_END:   pending_next = '0;
                default:  pending_next = pending_reg;
            endcase
        end
    end

    // stage two: accumulate, hand the total over on the terminator
    always_comb
    begin
        total_next     = total_reg;
        err_next       = err_reg;
        out_total_next = out_total_reg;
        out_err_next   = out_err_reg;
        out_valid_next = result.ready ? 1'b0 : out_valid_reg;
        if (s1_fire)
        begin
            if (s1_end_reg)
            begin
                out_total_next = sum;
                out_err_next   = err_sum;
                out_valid_next = 1'b1;
                total_next     = '0;
                err_next       = 1'b0;
            end
            else
            begin
                total_next = sum;
                err_next   = err_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            total_reg     <= '0;
            err_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_end_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            total_reg     <= total_next;
            err_reg       <= err_next;
            s1_valid_reg  <= s1_valid_next;
            s1_end_reg    <= s1_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg     <= s1_err_next;
        s1_product_reg <= s1_product_next;
        out_total_reg  <= out_total_next;
        out_err_reg    <= out_err_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.total_seconds     = out_total_reg;
    assign result.unknown_unit_seen = out_err_reg;

    assign stat.end_fire = s1_fire && s1_end_reg;

endmodule

// ===== src/duration_text_to_seconds.sv =====
// top level of the duration text parser: config register, front, queue, back
// depends on dtts_pkg, dtts_if, dtts_front, dtts_fifo, dtts_back, assert_macros.svh
`include "assert_macros.svh"

// Duration text parser. Characters arrive one per request on text (a zero
// byte ends the string); the total in seconds and the unknown-unit flag leave
// as one request on result for each terminator. One character is taken every
// cycle while the operation queue has room; the back end retires one queued
// operation per cycle through a multiply stage and an accumulate stage, save
// when a terminator waits behind an untaken result. A terminator passes the
// queue, the stage-one registers and the result register. The result register
// is separate from the accumulator, so characters of the next string keep
// flowing while a total waits to be taken, up to that string's terminator.
// The unit register for trailing numbers lies at byte address 0 of the APB
// port and must only be written while no string is in flight.
module duration_text_to_seconds #(
    parameter int QUEUE_DEPTH = dtts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dtts_char_if.sink                        text,
    dtts_result_if.source                    result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dtts_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [dtts_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dtts_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import dtts_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [CHAR_W-1:0]    fallback_unit_reg;
    logic [CHAR_W-1:0]    fallback_unit_next;
    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    logic                 q_push;
    dtts_entry_t          q_wr_entry;
    logic                 q_pop;
    dtts_entry_t          q_rd_entry;
    logic                 q_full;
    logic                 q_empty;
    logic [LVL_W-1:0]     q_level;
    dtts_back_stat_t      bk_stat;
    logic                 term_accept;

    // register port, word index from the upper address bits
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        fallback_unit_next = fallback_unit_reg;
        if (cfg_wr && cfg_idx == CFG_IDX_FALLBACK_UNIT)
        begin
            fallback_unit_next = pwdata[CHAR_W-1:0];
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_IDX_FALLBACK_UNIT: prdata = APB_DATA_W'(fallback_unit_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_unit_reg <= FALLBACK_UNIT_RESET;
        end
        else
        begin
            fallback_unit_reg <= fallback_unit_next;
        end
    end

    // front: phase tracking and classification, one leading delimiter per term dropped here
    dtts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .text          (text),
        .fallback_unit (fallback_unit_reg),
        .q_full        (q_full),
        .push          (q_push),
        .entry         (q_wr_entry)
    );

    // operation queue lets front and back stall apart
    dtts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .full     (q_full),
        .empty    (q_empty),
        .level    (q_level)
    );

    // back: number build, unit product, running total, result register
    dtts_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (q_rd_entry),
        .q_pop   (q_pop),
        .result  (result),
        .stat    (bk_stat)
    );

    // checks
    assign term_accept = text.valid && text.ready && text.char_code == CHAR_NUL;

    `ASSERT_CLK(a_level_bound, q_level <= LVL_W'(QUEUE_DEPTH), "queue level beyond depth")
    `ASSERT_CLK(a_term_queued, term_accept |=> q_level != '0, "terminator not queued")
    `ASSERT_CLK(a_result_origin, $rose(result.valid) |-> $past(bk_stat.end_fire), "stray result")

endmodule
